// ----- design/bfiq_pkg.sv -----
// Shared types, codes and constants for the Bloom filter insert/query block.
// No dependencies; imported by every module of the block.
`default_nettype none
package bfiq_pkg;

  localparam int DEF_MAX_WORDS  = 1024;
  localparam int DEF_MAX_PROBES = 30;

  localparam int WORD_W   = 64;
  localparam int HASH_W   = 64;
  localparam int HALF_W   = 32;
  localparam int PROBE_W  = 5;
  localparam int FWORDS_W = 11;
  localparam int REQ_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int BIT_IDX_W  = 6;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WORDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ALL   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } bfiq_state_t;

  typedef struct packed {
    logic load;  // take h1/h2 from the new key
    logic step;  // register product of current x, advance x by h2
  } bfiq_probe_ctrl_t;

  // address bits for a store of n words
  function automatic int addr_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // bits needed to hold a word count of 0..n
  function automatic int count_width(input int n);
    return $clog2(n + 1);
  endfunction

endpackage
`default_nettype wire

// ----- design/bloom_filter_insert_query_top.sv -----
// Top level of the Bloom filter insert/query block: config registers, sequencer,
// store RAM and output register. Depends on bfiq_pkg, bfiq_ram, bfiq_probe_unit.
//
// Each key brings a 64-bit hash; probes use double hashing x = h1 + i*h2 and
// position x * (64 * filter_words) >> 32. Insert and query run k probes
// (a query stops at the first clear bit): every probe passes through the shared
// multiplier (CALC), the single store read port (READ) and a check or write-back
// of the word (CHECK). Accept-all queries, empty filters, zero probes and
// unknown requests go straight to the completion state. A clear writes one word
// per cycle over all MAX_WORDS words. After reset the block runs a clearing
// pass over all MAX_WORDS words before taking its first item; config writes
// are taken at any time. A finished result waits in the output register while
// the next item is accepted.
`default_nettype none
module bloom_filter_insert_query_top
  import bfiq_pkg::*;
#(
  parameter int MAX_WORDS  = DEF_MAX_WORDS,
  parameter int MAX_PROBES = DEF_MAX_PROBES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [REQ_W-1:0]      in_req_type,
  input  wire logic [HASH_W-1:0]     in_key_hash,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [REQ_W-1:0]      out_req_kind,
  output logic                       out_maybe_present,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = addr_width(MAX_WORDS);
  localparam int WW = count_width(MAX_WORDS);
  localparam int CW = (WW > FWORDS_W) ? WW : FWORDS_W;

  // configuration
  logic [PROBE_W-1:0]  probe_count_r;
  logic [FWORDS_W-1:0] filter_words_r;
  logic                accept_all_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_count_r  <= PROBE_W'(7);
      filter_words_r <= '0;
      accept_all_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROBE_COUNT:  probe_count_r  <= cfg_data[PROBE_W-1:0];
        CFG_FILTER_WORDS: filter_words_r <= cfg_data[FWORDS_W-1:0];
        CFG_ACCEPT_ALL:   accept_all_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // saturated word and probe counts
  logic [CW-1:0]      words_ext;
  logic [WW-1:0]      words;
  logic [PROBE_W-1:0] probes;

  assign words_ext = CW'(filter_words_r);
  assign words = (words_ext > CW'(MAX_WORDS)) ? WW'(MAX_WORDS) : words_ext[WW-1:0];
  assign probes = (probe_count_r > PROBE_W'(MAX_PROBES)) ? PROBE_W'(MAX_PROBES)
                                                         : probe_count_r;

  // probe unit and store
  bfiq_probe_ctrl_t     pctrl;
  logic [AW-1:0]        probe_addr;
  logic [BIT_IDX_W-1:0] probe_bit;

  bfiq_probe_unit #(.MAX_WORDS(MAX_WORDS)) u_probe (
    .clk       (clk),
    .ctrl      (pctrl),
    .key_hash  (in_key_hash),
    .words     (words),
    .word_addr (probe_addr),
    .bit_idx   (probe_bit)
  );

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  bfiq_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (probe_addr),
    .rdata (ram_rdata)
  );

  // sequencer
  bfiq_state_t        state_r, state_nxt;
  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [PROBE_W-1:0] cnt_r, cnt_nxt;
  logic               hit_r, hit_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               clr_reply_r, clr_reply_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [REQ_W-1:0]   out_kind_r, out_kind_nxt;
  logic               out_present_r, out_present_nxt;

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    cnt_nxt         = cnt_r;
    hit_nxt         = hit_r;
    clr_addr_nxt    = clr_addr_r;
    clr_reply_nxt   = clr_reply_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_kind_nxt    = out_kind_r;
    out_present_nxt = out_present_r;
    pctrl           = '0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_waddr       = probe_addr;
    ram_wdata       = ram_rdata | (WORD_W'(1) << probe_bit);
    in_stall        = (state_r != ST_IDLE);

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_WORDS - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = clr_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          req_nxt    = in_req_type;
          cnt_nxt    = probes;
          hit_nxt    = 1'b0;
          pctrl.load = 1'b1;
          state_nxt  = ST_DONE;
          case (in_req_type)
            REQ_INSERT: begin
              if (words != '0 && probes != '0) begin
                state_nxt = ST_CALC;
              end
            end
            REQ_QUERY: begin
              if (accept_all_r) begin
                hit_nxt = 1'b1;
              end else if (words != '0) begin
                hit_nxt = 1'b1;
                if (probes != '0) begin
                  state_nxt = ST_CALC;
                end
              end
            end
            REQ_CLEAR: begin
              clr_reply_nxt = 1'b1;
              clr_addr_nxt  = '0;
              state_nxt     = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_CALC: begin
        pctrl.step = 1'b1;
        state_nxt  = ST_READ;
      end
      ST_READ: begin
        ram_re    = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cnt_nxt   = cnt_r - PROBE_W'(1);
        state_nxt = (cnt_r == PROBE_W'(1)) ? ST_DONE : ST_CALC;
        if (req_r == REQ_INSERT) begin
          ram_we = 1'b1;
        end else if (!ram_rdata[probe_bit]) begin
          // drop remaining probes on the first clear bit
          hit_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = req_r;
          out_present_nxt = hit_r;
          clr_reply_nxt   = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    hit_r         <= hit_nxt;
    out_kind_r    <= out_kind_nxt;
    out_present_r <= out_present_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_req_kind      = out_kind_r;
  assign out_maybe_present = out_present_r;

  // a result appears only out of the completion state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside completion state");

  // the store port never reads and writes in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store read and write overlap");

  // probe loop always has probes left
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC || state_r == ST_READ || state_r == ST_CHECK) |-> cnt_r != '0)
    else $error("probe loop running with no probes left");

  // a clear reply carries the clear code
  a_clear_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && clr_reply_r) |-> req_r == REQ_CLEAR)
    else $error("clear reply with wrong request kind");

endmodule
`default_nettype wire

// ----- design/bfiq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on bfiq_pkg for the address width helper.
`default_nettype none
module bfiq_ram
  import bfiq_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = addr_width(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/bfiq_probe_unit.sv -----
// Shared probe position unit: one adder steps x = h1 + i*h2, one multiplier
// scales x by the active word count. Depends on bfiq_pkg.
`default_nettype none
module bfiq_probe_unit
  import bfiq_pkg::*;
#(
  parameter int MAX_WORDS = DEF_MAX_WORDS,
  localparam int AW = addr_width(MAX_WORDS),
  localparam int WW = count_width(MAX_WORDS)
) (
  input  wire logic                 clk,
  input  wire bfiq_probe_ctrl_t     ctrl,
  input  wire logic [HASH_W-1:0]    key_hash,
  input  wire logic [WW-1:0]        words,
  output logic      [AW-1:0]        word_addr,
  output logic      [BIT_IDX_W-1:0] bit_idx
);

  localparam int PW = HALF_W + WW;

  logic [HALF_W-1:0] x_r, x_nxt;
  logic [HALF_W-1:0] h2_r, h2_nxt;
  logic [PW-1:0]     prod_r, prod_nxt;

  always_comb begin
    x_nxt    = x_r;
    h2_nxt   = h2_r;
    prod_nxt = prod_r;
    if (ctrl.load) begin
      x_nxt  = key_hash[HALF_W-1:0];
      h2_nxt = key_hash[HASH_W-1:HALF_W];
    end else if (ctrl.step) begin
      prod_nxt = PW'(x_r) * PW'(words);
      x_nxt    = x_r + h2_r;  // wraps mod 2^32
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    h2_r   <= h2_nxt;
    prod_r <= prod_nxt;
  end

  // bit position = (x * words * 64) >> 32: word in the top bits, bit below
  assign word_addr = prod_r[HALF_W +: AW];
  assign bit_idx   = prod_r[HALF_W-1 -: BIT_IDX_W];

endmodule
`default_nettype wire

// ----- bench/bloom_filter_insert_query_top_tb.sv -----
// Self-checking bench for bloom_filter_insert_query_top: a directed table, then
// randomized insert/query/clear traffic under several filter settings and idle
// patterns, scored against a local filter model. Depends on bfiq_pkg and the RTL.
module bloom_filter_insert_query_top_tb;
  import bfiq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int DIR_ROWS    = 29;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 80;
  localparam int RECENT_KEYS = 16;
  localparam int TAIL_CYCLES = 3 * DEF_MAX_PROBES + 8;

  // per-phase filter settings and idle pattern
  localparam int PH_PROBES [PHASES] = '{7, 1, 30, 3, 31, 0, 12, 5};
  localparam int PH_WORDS  [PHASES] = '{4, 1, 16, 1024, 2, 8, 2047, 0};
  localparam int PH_ACCEPT [PHASES] = '{0, 0, 0, 0, 0, 0, 1, 0};
  localparam int SEND_PCT  [4]      = '{0, 53, 0, 13};
  localparam int STALL_PCT [4]      = '{0, 0, 53, 13};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic [REQ_W-1:0]      req;
    logic [HASH_W-1:0]     key;
    logic                  fixed;
    logic                  fixed_present;
  } stim_row_t;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic             present;
  } answer_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [REQ_W-1:0]      in_req_type;
  logic [HASH_W-1:0]     in_key_hash;
  logic                  out_valid;
  logic                  out_stall;
  logic [REQ_W-1:0]      out_req_kind;
  logic                  out_maybe_present;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // local copy of the configuration and the bit store
  logic [PROBE_W-1:0]  k_reg;
  logic [FWORDS_W-1:0] words_reg;
  logic                accept_reg;
  logic [WORD_W-1:0]   bloom_bits [DEF_MAX_WORDS];

  answer_t       pending_answers [$];
  answer_t       head_answer;
  logic [HASH_W-1:0] recent_keys [$];
  stim_row_t     directed_tbl [DIR_ROWS];

  int errors;
  int send_idle_pct;
  int stall_pct;
  int n_inserts, n_queries, n_present, n_clears, n_unknown;

  bloom_filter_insert_query_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_key_hash       (in_key_hash),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_req_kind      (out_req_kind),
    .out_maybe_present (out_maybe_present),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one request to the local filter; return the expected query answer.
  function automatic logic filter_apply(input logic [REQ_W-1:0] req,
                                        input logic [HASH_W-1:0] key);
    logic [HALF_W-1:0] h1, h2, x, step_i;
    logic [63:0]       num_bits, prod;
    logic [15:0]       pos;
    logic              present;
    int                words, k, p;
    h1 = key[HALF_W-1:0];
    h2 = key[HASH_W-1:HALF_W];
    words = (words_reg > DEF_MAX_WORDS) ? DEF_MAX_WORDS : int'(words_reg);
    k = (k_reg > DEF_MAX_PROBES) ? DEF_MAX_PROBES : int'(k_reg);
    num_bits = 64'(words) * 64'd64;
    present = 1'b0;
    case (req)
      REQ_INSERT: begin
        if (words != 0) begin
          for (p = 0; p < k; p++) begin
            step_i = p;
            x = h1 + step_i * h2;
            prod = 64'(x) * num_bits;
            pos = prod[47:32];
            bloom_bits[pos[15:6]][pos[5:0]] = 1'b1;
          end
        end
      end
      REQ_QUERY: begin
        if (accept_reg) begin
          present = 1'b1;
        end else if (words != 0) begin
          present = 1'b1;
          for (p = 0; p < k; p++) begin
            step_i = p;
            x = h1 + step_i * h2;
            prod = 64'(x) * num_bits;
            pos = prod[47:32];
            if (!bloom_bits[pos[15:6]][pos[5:0]]) present = 1'b0;
          end
        end
      end
      REQ_CLEAR: begin
        for (p = 0; p < DEF_MAX_WORDS; p++) bloom_bits[p] = '0;
      end
      default: ;
    endcase
    return present;
  endfunction

  // Call right after a rising edge; returns at the edge of the transfer.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [HASH_W-1:0] key,
                              input logic fixed, input logic fixed_present);
    answer_t ans;
    logic    present;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_key_hash <= key;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    present = filter_apply(req, key);
    ans.kind = req;
    ans.present = fixed ? fixed_present : present;
    pending_answers = {pending_answers, ans};
    case (req)
      REQ_INSERT: n_inserts++;
      REQ_QUERY: begin
        n_queries++;
        if (present) n_present++;
      end
      REQ_CLEAR: n_clears++;
      default: n_unknown++;
    endcase
  endtask

  // Hold the sender until every outstanding answer has come back.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_PROBE_COUNT:  k_reg = data[PROBE_W-1:0];
      CFG_FILTER_WORDS: words_reg = data[FWORDS_W-1:0];
      CFG_ACCEPT_ALL:   accept_reg = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d present %0b",
                 $time, out_req_kind, out_maybe_present);
        errors++;
      end else begin
        head_answer = pending_answers.pop_front();
        if (out_req_kind !== head_answer.kind) begin
          $display("%0t: req_kind mismatch: expected %0d, actual %0d",
                   $time, head_answer.kind, out_req_kind);
          errors++;
        end
        if (out_maybe_present !== head_answer.present) begin
          $display("%0t: maybe_present mismatch: expected %0b, actual %0b",
                   $time, head_answer.present, out_maybe_present);
          errors++;
        end
      end
    end
  end

  initial begin
    #30000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [REQ_W-1:0]  req;
    logic [HASH_W-1:0] key;
    int                roll, ph, n, w;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = REQ_INSERT;
    in_key_hash = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_PROBE_COUNT;
    cfg_data    = '0;
    k_reg       = 5'd7;
    words_reg   = '0;
    accept_reg  = 1'b0;
    for (w = 0; w < DEF_MAX_WORDS; w++) bloom_bits[w] = '0;
    errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    n_inserts = 0;
    n_queries = 0;
    n_present = 0;
    n_clears = 0;
    n_unknown = 0;

    directed_tbl = '{
      // reset settings: empty filter, seven probes
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, 64'h0, 1'b1, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_INSERT, '1, 1'b1, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, '1, 1'b1, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_UNKNOWN, 64'h0123_4567_89ab_cdef, 1'b1, 1'b0},
      // accept-all query, then accept-all insert into the full-size filter
      '{ROW_CFG, CFG_ACCEPT_ALL, 11'd1, REQ_INSERT, 64'h0, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, 64'h0, 1'b1, 1'b1},
      '{ROW_CFG, CFG_FILTER_WORDS, 11'd1024, REQ_INSERT, 64'h0, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_INSERT, '1, 1'b1, 1'b0},
      '{ROW_CFG, CFG_ACCEPT_ALL, 11'd0, REQ_INSERT, 64'h0, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, '1, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, 64'h0, 1'b0, 1'b0},
      // probe count above the maximum saturates
      '{ROW_CFG, CFG_PROBE_COUNT, 11'd31, REQ_INSERT, 64'h0, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_INSERT, 64'h0000_0001_8000_0000, 1'b1, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, 64'h0000_0001_8000_0000, 1'b0, 1'b0},
      // zero probes: insert does nothing, query on a sized filter hits
      '{ROW_CFG, CFG_PROBE_COUNT, 11'd0, REQ_INSERT, 64'h0, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_INSERT, 64'h1234_5678_9abc_def0, 1'b1, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, 64'h0fed_cba9_8765_4321, 1'b1, 1'b1},
      // oversized filter saturates; clear wipes the store
      '{ROW_CFG, CFG_FILTER_WORDS, 11'd2047, REQ_INSERT, 64'h0, 1'b0, 1'b0},
      '{ROW_CFG, CFG_PROBE_COUNT, 11'd1, REQ_INSERT, 64'h0, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_INSERT, 64'haaaa_aaaa_5555_5555, 1'b1, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, 64'haaaa_aaaa_5555_5555, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, 64'h5555_5555_aaaa_aaaa, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_CLEAR, 64'h0, 1'b1, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, 64'haaaa_aaaa_5555_5555, 1'b1, 1'b0},
      // one-word filter, maximum probes, extreme halves
      '{ROW_CFG, CFG_FILTER_WORDS, 11'd1, REQ_INSERT, 64'h0, 1'b0, 1'b0},
      '{ROW_CFG, CFG_PROBE_COUNT, 11'd30, REQ_INSERT, 64'h0, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_INSERT, 64'hffff_ffff_0000_0000, 1'b1, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_QUERY, 64'h0000_0000_ffff_ffff, 1'b0, 1'b0},
      '{ROW_ITEM, CFG_PROBE_COUNT, 11'd0, REQ_UNKNOWN, '1, 1'b1, 1'b0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tbl[r]) begin
      if (directed_tbl[r].kind == ROW_CFG) begin
        drain;
        cfg_write(directed_tbl[r].cfg_idx, directed_tbl[r].cfg_val);
      end else begin
        send_request(directed_tbl[r].req, directed_tbl[r].key,
                     directed_tbl[r].fixed, directed_tbl[r].fixed_present);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain;
      send_idle_pct = SEND_PCT[ph % 4];
      stall_pct = STALL_PCT[ph % 4];
      // unused upper data bits are random; the block must ignore them
      cfg_write(CFG_PROBE_COUNT, {6'($urandom_range(63)), PROBE_W'(PH_PROBES[ph])});
      cfg_write(CFG_FILTER_WORDS, FWORDS_W'(PH_WORDS[ph]));
      cfg_write(CFG_ACCEPT_ALL, {10'($urandom_range(1023)), 1'(PH_ACCEPT[ph])});
      recent_keys.delete();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && ph % 2 == 1) drain;
        roll = $urandom_range(99);
        key = {$urandom, $urandom};
        if (roll < 3) begin
          req = REQ_CLEAR;
          recent_keys.delete();
        end else if (roll < 6) begin
          req = REQ_UNKNOWN;
        end else if (roll < 46) begin
          req = REQ_INSERT;
          recent_keys = {recent_keys, key};
          if (recent_keys.size() > RECENT_KEYS) void'(recent_keys.pop_front());
        end else begin
          req = REQ_QUERY;
          // mostly re-ask inserted keys, sometimes with one bit flipped
          if (recent_keys.size() != 0 && $urandom_range(99) < 60) begin
            key = recent_keys[$urandom_range(recent_keys.size() - 1)];
            if ($urandom_range(4) == 0) key[$urandom_range(63)] ^= 1'b1;
          end
        end
        send_request(req, key, 1'b0, 1'b0);
      end
    end

    drain;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d inserts, %0d queries (%0d present), %0d clears, %0d unknown",
             n_inserts, n_queries, n_present, n_clears, n_unknown);
    $display("over %0d filter settings and four idle/stall patterns", PHASES);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bfiq_pkg.sv
design/bfiq_ram.sv
design/bfiq_probe_unit.sv
design/bloom_filter_insert_query_top.sv
bench/bloom_filter_insert_query_top_tb.sv
